// ----- hdl/fmpa_pkg.sv -----
// Shared types and constants of the first-match packet ACL.
package fmpa_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_WRITE    = 2'd0;
  localparam logic [1:0] REQ_CLASSIFY = 2'd1;

  // Protocol numbers that take part in port matching
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Action reported when no rule decides
  localparam logic [2:0] ACT_PASS = 3'd2;

  // Field widths of the streams
  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned IDX_FIELD_W = 3;

  // One stored rule
  typedef struct packed {
    logic        enable;
    logic [2:0]  verdict;
    logic [7:0]  protocol;
    logic        port_check;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_mask;
  } rule_t;

  localparam int unsigned RULE_W = $bits(rule_t);

  // Header fields of a packet under classification
  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } key_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_e;

endpackage

// ----- hdl/fmpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fmpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Store on write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/fmpa_rule_eval.sv -----
// Match test of one stored rule against a packet header.
module fmpa_rule_eval (
  input  fmpa_pkg::rule_t rule_i,
  input  logic            valid_i,
  input  fmpa_pkg::key_t  key_i,
  output logic            hit_o
);

  logic proto_ok;
  logic src_ok;
  logic dst_ok;
  logic port_ok;
  logic ports_on;

  // Protocol: zero in the rule matches any
  assign proto_ok = (rule_i.protocol == 8'd0) || (rule_i.protocol == key_i.protocol);

  // Addresses: zero matches any, a mask compares under it, else exact
  always_comb begin
    if (rule_i.src_addr == 32'd0) begin
      src_ok = 1'b1;
    end else if (rule_i.src_mask != 32'd0) begin
      src_ok = (key_i.src_addr & rule_i.src_mask) == (rule_i.src_addr & rule_i.src_mask);
    end else begin
      src_ok = key_i.src_addr == rule_i.src_addr;
    end
    if (rule_i.dst_addr == 32'd0) begin
      dst_ok = 1'b1;
    end else if (rule_i.dst_mask != 32'd0) begin
      dst_ok = (key_i.dst_addr & rule_i.dst_mask) == (rule_i.dst_addr & rule_i.dst_mask);
    end else begin
      dst_ok = key_i.dst_addr == rule_i.dst_addr;
    end
  end

  // Ports count only for UDP or TCP rules with port checking on
  assign ports_on = rule_i.port_check &&
                    ((rule_i.protocol == fmpa_pkg::PROTO_UDP) ||
                     (rule_i.protocol == fmpa_pkg::PROTO_TCP));
  assign port_ok  = !ports_on ||
                    (((rule_i.src_port == 16'd0) || (rule_i.src_port == key_i.src_port)) &&
                     ((rule_i.dst_port == 16'd0) || (rule_i.dst_port == key_i.dst_port)));

  // An entry never written reads as disabled
  assign hit_o = valid_i && rule_i.enable && proto_ok && src_ok && dst_ok && port_ok;

endmodule

// ----- hdl/first_match_packet_acl.sv -----
// Top level of the first-match packet ACL: sequencer, rule table and result register.
//
// The rule table sits in a single RAM with one read port, and a classify beat walks it
// one rule per cycle from slot 0 up, stopping at the first rule that matches (the last
// slot when none matches). Beats are taken only while the sequencer is idle, so a new
// beat waits until the previous one has loaded its result into the output register.
// Rule writes, and beats of any other request kind, skip the walk and load a pass
// result. The result sits in an output register, so a finished walk does not wait on
// the consumer unless a previous result is still held there. Slots that have never
// been written read as disabled after reset.
module first_match_packet_acl #(
  parameter int unsigned NUM_RULES = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // rule_index, rule_enable, verdict, protocol, src_addr, src_mask, dst_addr,
  // dst_mask, port_check, src_port, dst_port
  input  logic [fmpa_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // req_type
  input  logic [fmpa_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // action, matched, match_index, one zero pad bit
  output logic [fmpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned IdxW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int unsigned WideW = (IdxW > fmpa_pkg::IDX_FIELD_W) ? IdxW
                                                                 : fmpa_pkg::IDX_FIELD_W;

  // Input beat fields
  logic [2:0]  in_rule_index;
  logic        in_rule_enable;
  logic [2:0]  in_verdict;
  logic [7:0]  in_protocol;
  logic [31:0] in_src_addr;
  logic [31:0] in_src_mask;
  logic [31:0] in_dst_addr;
  logic [31:0] in_dst_mask;
  logic        in_port_check;
  logic [15:0] in_src_port;
  logic [15:0] in_dst_port;

  assign in_rule_index  = s_axis_tdata_i[2:0];
  assign in_rule_enable = s_axis_tdata_i[3];
  assign in_verdict     = s_axis_tdata_i[6:4];
  assign in_protocol    = s_axis_tdata_i[14:7];
  assign in_src_addr    = s_axis_tdata_i[46:15];
  assign in_src_mask    = s_axis_tdata_i[78:47];
  assign in_dst_addr    = s_axis_tdata_i[110:79];
  assign in_dst_mask    = s_axis_tdata_i[142:111];
  assign in_port_check  = s_axis_tdata_i[143];
  assign in_src_port    = s_axis_tdata_i[159:144];
  assign in_dst_port    = s_axis_tdata_i[175:160];

  fmpa_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  fmpa_pkg::key_t       key_q;
  logic [NUM_RULES-1:0] valid_q, valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_action_q, out_action_d;
  logic                 out_matched_q, out_matched_d;
  logic [2:0]           out_index_q, out_index_d;

  logic                 s_accept;
  logic                 is_classify;
  logic                 slot_free;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  fmpa_pkg::rule_t      wr_rule;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  fmpa_pkg::rule_t      rd_rule;
  logic                 rule_hit;
  logic                 last_rule;
  logic                 advance;
  logic                 out_load;
  logic [WideW-1:0]     idx_wide;

  assign s_axis_tready_o = (state_q == fmpa_pkg::ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign is_classify     = (s_axis_tuser_i == fmpa_pkg::REQ_CLASSIFY);
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign last_rule       = (32'(idx_q) == NUM_RULES - 1);

  // Store a rule on a write beat with an index in range
  assign wr_en   = s_accept && (s_axis_tuser_i == fmpa_pkg::REQ_WRITE) &&
                   (32'(in_rule_index) < NUM_RULES);
  assign wr_addr = IdxW'(in_rule_index);

  always_comb begin
    wr_rule.enable     = in_rule_enable;
    wr_rule.verdict    = in_verdict;
    wr_rule.protocol   = in_protocol;
    wr_rule.port_check = in_port_check;
    wr_rule.src_port   = in_src_port;
    wr_rule.dst_port   = in_dst_port;
    wr_rule.src_addr   = in_src_addr;
    wr_rule.dst_addr   = in_dst_addr;
    wr_rule.src_mask   = in_src_mask;
    wr_rule.dst_mask   = in_dst_mask;
  end

  // Mark written slots
  always_comb begin
    valid_d = valid_q;
    if (wr_en) begin
      valid_d[wr_addr] = 1'b1;
    end
  end

  // Issue slot 0 on a classify beat, then the next slot or the same one on a stall
  assign advance = (state_q == fmpa_pkg::ST_WALK) && !rule_hit && !last_rule;
  assign rd_en   = (s_accept && is_classify) || (state_q == fmpa_pkg::ST_WALK);
  always_comb begin
    if (s_accept) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = IdxW'(idx_q + 1'b1);
    end else begin
      rd_addr = idx_q;
    end
  end

  fmpa_ram #(
    .WIDTH (fmpa_pkg::RULE_W),
    .DEPTH (NUM_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_rule),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_rule)
  );

  fmpa_rule_eval u_rule_eval (
    .rule_i  (rd_rule),
    .valid_i (valid_q[idx_q]),
    .key_i   (key_q),
    .hit_o   (rule_hit)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmpa_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_d = is_classify ? fmpa_pkg::ST_WALK : fmpa_pkg::ST_RESP;
        end
      end
      fmpa_pkg::ST_WALK: begin
        if ((rule_hit || last_rule) && slot_free) begin
          state_d = fmpa_pkg::ST_IDLE;
        end
      end
      fmpa_pkg::ST_RESP: begin
        if (slot_free) begin
          state_d = fmpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fmpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign idx_wide = WideW'(idx_q);

  // Result and walk index
  always_comb begin
    out_load      = 1'b0;
    out_action_d  = fmpa_pkg::ACT_PASS;
    out_matched_d = 1'b0;
    out_index_d   = '0;
    idx_d         = idx_q;
    case (state_q)
      fmpa_pkg::ST_IDLE: begin
        if (s_accept) begin
          idx_d = '0;
        end
      end
      fmpa_pkg::ST_WALK: begin
        if (rule_hit) begin
          out_load      = slot_free;
          out_action_d  = rd_rule.verdict;
          out_matched_d = 1'b1;
          out_index_d   = idx_wide[2:0];
        end else if (last_rule) begin
          out_load = slot_free;
        end else begin
          idx_d = IdxW'(idx_q + 1'b1);
        end
      end
      fmpa_pkg::ST_RESP: begin
        out_load = slot_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Hold the result until the beat is taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmpa_pkg::ST_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the packet key and the result payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      key_q.protocol <= in_protocol;
      key_q.src_addr <= in_src_addr;
      key_q.dst_addr <= in_dst_addr;
      key_q.src_port <= in_src_port;
      key_q.dst_port <= in_dst_port;
    end
    if (out_load) begin
      out_action_q  <= out_action_d;
      out_matched_q <= out_matched_d;
      out_index_q   <= out_index_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_index_q, out_matched_q, out_action_q};

endmodule

// ----- hdl/fmpa_checker.sv -----
// Port-level checks of the first-match packet ACL, bound to the top level.
module fmpa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [fmpa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // Stalled result beat holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // Only one item in flight: no beat taken in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

  // An unmatched result is pass with index zero and a clear pad bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[3] |->
      (m_axis_tdata_o[2:0] == fmpa_pkg::ACT_PASS) && (m_axis_tdata_o[7:4] == 4'd0))
    else $error("unmatched result carries a rule action or index");

endmodule

bind first_match_packet_acl fmpa_checker u_fmpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
